/* design/fprs_pkg.sv */
package fprs_pkg;

    // reduction phases of the sequencer
    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_LCM    = 3'd2,
        PH_SUM    = 3'd3,
        PH_QUO    = 3'd4
    } phase_t;

endpackage

/* design/fprs_divider.sv */
// Restoring divider, one quotient bit per cycle. Division by zero gives zero.
module fprs_divider #(
    parameter int W = 33
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    assign shifted = {r_reg, q_reg[W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[W]) begin
                    r_reg <= trial[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end else begin
                    r_reg <= shifted[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = (d_reg == '0) ? '0 : q_reg;
    assign remainder = (d_reg == '0) ? '0 : r_reg;

endmodule

/* design/fraction_pair_reduce_sum_quotient.sv */
// Reduces two fractions, brings them to their least common denominator and
// gives the reduced sum and quotient. Every remainder and quotient goes
// through one shared restoring divider under a sequencer. The Euclid loops
// are data dependent, so the time per item varies with the operands.
// s_tready is high only while the sequencer is idle; a finished result
// waits in the output register and holds the sequencer at its last step
// only if the previous beat is still unread.
module fraction_pair_reduce_sum_quotient #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // n1, d1, n2, d2 from the lowest bit up
    input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // a, b, lden, sn, sd, qn, qd from the lowest bit up
    output logic [((14*VALUE_WIDTH+1+7)/8)*8-1:0] m_tdata
);
    import fprs_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int WW = 2 * VW;
    localparam int SW = 2 * VW + 1;
    localparam int OW = ((14 * VW + 1 + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_IDLE, S_G_INIT, S_G_DIV, S_G_WAIT, S_DIVN, S_DIVN_W, S_DIVD, S_DIVD_W,
        S_LCM_G, S_LCM_D, S_LCM_DW, S_A_D, S_A_DW, S_B_D, S_B_DW, S_SUM, S_QUO,
        S_OUT
    } state_t;

    state_t state_reg;
    phase_t phase_reg;      // which reduction is running
    logic [SW-1:0] x_reg, y_reg, g_reg, pn_reg, pd_reg, sn_reg;
    logic [WW-1:0] n1_reg, d1_reg, n2_reg, d2_reg, l_reg, a_reg, b_reg, sd_reg;
    logic [SW-1:0] dv_a_reg, dv_b_reg;
    logic dv_start_reg;
    logic dv_done;
    logic [SW-1:0] dv_q, dv_r;
    logic out_v_reg;
    logic [OW-1:0] out_reg;

    fprs_divider #(.W(SW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start_reg),
        .dividend(dv_a_reg), .divisor(dv_b_reg),
        .done(dv_done), .quotient(dv_q), .remainder(dv_r)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_FIRST;
            dv_start_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end else begin
            dv_start_reg <= 1'b0;
            if (out_v_reg && m_tready && state_reg != S_OUT) out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        n1_reg    <= WW'(s_tdata[VW-1:0]);
                        d1_reg    <= WW'(s_tdata[2*VW-1:VW]);
                        n2_reg    <= WW'(s_tdata[3*VW-1:2*VW]);
                        d2_reg    <= WW'(s_tdata[4*VW-1:3*VW]);
                        pn_reg    <= SW'(s_tdata[VW-1:0]);
                        pd_reg    <= SW'(s_tdata[2*VW-1:VW]);
                        phase_reg <= PH_FIRST;
                        state_reg <= S_G_INIT;
                    end
                end
                S_G_INIT: begin
                    x_reg     <= pn_reg;
                    y_reg     <= pd_reg;
                    state_reg <= S_G_DIV;
                end
                S_G_DIV: begin
                    if (x_reg == '0 || y_reg == '0) begin
                        g_reg     <= x_reg + y_reg;
                        state_reg <= (phase_reg == PH_LCM) ? S_LCM_G : S_DIVN;
                    end else begin
                        dv_a_reg     <= x_reg;
                        dv_b_reg     <= y_reg;
                        dv_start_reg <= 1'b1;
                        state_reg    <= S_G_WAIT;
                    end
                end
                S_G_WAIT: if (dv_done) begin
                    x_reg     <= y_reg;
                    y_reg     <= dv_r;
                    state_reg <= S_G_DIV;
                end
                S_DIVN: begin
                    dv_a_reg <= pn_reg; dv_b_reg <= g_reg; dv_start_reg <= 1'b1;
                    state_reg <= S_DIVN_W;
                end
                S_DIVN_W: if (dv_done) begin
                    pn_reg <= dv_q; state_reg <= S_DIVD;
                end
                S_DIVD: begin
                    dv_a_reg <= pd_reg; dv_b_reg <= g_reg; dv_start_reg <= 1'b1;
                    state_reg <= S_DIVD_W;
                end
                S_DIVD_W: if (dv_done) begin
                    case (phase_reg)
                        PH_FIRST: begin
                            n1_reg <= pn_reg[WW-1:0];
                            d1_reg <= dv_q[WW-1:0];
                            pn_reg <= SW'(n2_reg); pd_reg <= SW'(d2_reg);
                            phase_reg <= PH_SECOND; state_reg <= S_G_INIT;
                        end
                        PH_SECOND: begin
                            n2_reg <= pn_reg[WW-1:0];
                            d2_reg <= dv_q[WW-1:0];
                            pn_reg <= SW'(d1_reg); pd_reg <= SW'(dv_q[WW-1:0]);
                            phase_reg <= PH_LCM; state_reg <= S_G_INIT;
                        end
                        PH_SUM: begin
                            pd_reg <= dv_q; state_reg <= S_QUO;
                        end
                        default: begin
                            pd_reg <= dv_q; state_reg <= S_OUT;
                        end
                    endcase
                end
                S_LCM_G: begin
                    // lden = d1*d2 / g
                    dv_a_reg <= SW'(d1_reg * d2_reg); dv_b_reg <= g_reg;
                    dv_start_reg <= 1'b1; state_reg <= S_LCM_DW;
                end
                S_LCM_D: state_reg <= S_LCM_DW;
                S_LCM_DW: if (dv_done) begin
                    l_reg <= dv_q[WW-1:0]; state_reg <= S_A_D;
                end
                S_A_D: begin
                    dv_a_reg <= SW'(l_reg); dv_b_reg <= SW'(d1_reg);
                    dv_start_reg <= 1'b1; state_reg <= S_A_DW;
                end
                S_A_DW: if (dv_done) begin
                    a_reg <= WW'(n1_reg * dv_q[WW-1:0]); state_reg <= S_B_D;
                end
                S_B_D: begin
                    dv_a_reg <= SW'(l_reg); dv_b_reg <= SW'(d2_reg);
                    dv_start_reg <= 1'b1; state_reg <= S_B_DW;
                end
                S_B_DW: if (dv_done) begin
                    b_reg <= WW'(n2_reg * dv_q[WW-1:0]); state_reg <= S_SUM;
                end
                S_SUM: begin
                    pn_reg <= SW'(a_reg) + SW'(b_reg); pd_reg <= SW'(l_reg);
                    phase_reg <= PH_SUM; state_reg <= S_G_INIT;
                end
                S_QUO: begin
                    sn_reg <= pn_reg;
                    sd_reg <= pd_reg[WW-1:0];
                    pn_reg <= SW'(a_reg); pd_reg <= SW'(b_reg);
                    phase_reg <= PH_QUO; state_reg <= S_G_INIT;
                end
                S_OUT: begin
                    // wait here while the previous beat is still held
                    if (!out_v_reg || m_tready) begin
                        out_reg <= OW'({pd_reg[WW-1:0], pn_reg[WW-1:0], sd_reg,
                                        sn_reg, l_reg, b_reg, a_reg});
                        out_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg != S_IDLE) |-> !s_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
            (out_v_reg && !m_tready) |=> (out_v_reg && $stable(out_reg));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_div_start_idle;
        @(posedge aclk) disable iff (!aresetn) dv_start_reg |-> (state_reg != S_IDLE);
    endproperty
    a_div_start_idle: assert property (p_div_start_idle) else $error("divider start idle");

endmodule
